/* sv/cbd_pkg.sv */
// Shared constants, configuration codes and transfer types for the chroma box
// downsampler. No dependencies; design files use scoped names, the testbench imports it.
package cbd_pkg;

  localparam int MAX_WIDTH   = 32;
  localparam int MAX_HEIGHT  = 32;

  localparam int POS_W       = 6;
  localparam int SAMPLE_W    = 8;
  localparam int HSUM_W      = 10;
  localparam int ACC_W       = 12;
  localparam int RATIO_W     = 3;
  localparam int CFG_W       = 6;
  localparam int CFG_IDX_W   = 2;
  localparam int COL_IDX_W   = $clog2(MAX_WIDTH);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HORIZ_RATIO   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VERT_RATIO    = 2'd3;

  localparam logic [POS_W-1:0]   RESET_WIDTH  = 6'd16;
  localparam logic [POS_W-1:0]   RESET_HEIGHT = 6'd16;
  localparam logic [RATIO_W-1:0] RESET_HORIZ  = 3'd2;
  localparam logic [RATIO_W-1:0] RESET_VERT   = 3'd2;

  // Odd factor of the group size (the power-of-two part is a shift)
  localparam logic [1:0] DIV_ONE   = 2'd0;
  localparam logic [1:0] DIV_THREE = 2'd1;
  localparam logic [1:0] DIV_NINE  = 2'd2;

  // floor(x * RECIP >> SHIFT) == floor(x / d) for every ACC_W-bit x
  localparam logic [ACC_W-1:0] RECIP3       = 12'd2731;
  localparam int               RECIP3_SHIFT = 13;
  localparam logic [ACC_W-1:0] RECIP9       = 12'd3641;
  localparam int               RECIP9_SHIFT = 15;

  typedef struct packed {
    logic [POS_W-1:0]   width;
    logic [POS_W-1:0]   height;
    logic [RATIO_W-1:0] horiz;
    logic [RATIO_W-1:0] vert;
  } cfg_t;

  // One completed horizontal group, handed from front to back
  typedef struct packed {
    logic [HSUM_W-1:0]    hsum;
    logic [COL_IDX_W-1:0] column;
    logic                 column_ok;
    logic                 fresh;
    logic                 emit;
    logic                 last;
    logic [2:0]           div_shift;
    logic [1:0]           div_mode;
  } group_t;

  typedef struct packed {
    logic              not_empty;
    logic              full;
    logic [QCNT_W-1:0] count;
  } queue_status_t;

endpackage

/* sv/cbd_if.sv */
// Valid/ready channel interfaces for the chroma box downsampler.
// Depends on cbd_pkg for payload widths.
interface sample_if;
  logic                         valid;
  logic                         ready;
  logic [cbd_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface average_if;
  logic                         valid;
  logic                         ready;
  logic [cbd_pkg::SAMPLE_W-1:0] average;
  logic                         last_of_region;

  modport source (output valid, output average, output last_of_region, input ready);
  modport sink   (input valid, input average, input last_of_region, output ready);
endinterface

/* sv/cbd_front.sv */
// Front end: accepts samples, tracks raster position and the horizontal sum,
// and queues one record per completed horizontal group. Depends on cbd_pkg, cbd_if.
module cbd_front (
  input  logic                  clk,
  input  logic                  rst,
  input  cbd_pkg::cfg_t         cfg,
  sample_if.sink                sample_ch,
  input  cbd_pkg::queue_status_t qstat,
  output logic                  push,
  output cbd_pkg::group_t       entry
);

  typedef struct packed {
    logic [cbd_pkg::POS_W-1:0] q;
    logic [1:0]                r;
  } quot_t;

  function automatic quot_t ratio_split(input logic [cbd_pkg::POS_W-1:0] x,
                                        input logic [cbd_pkg::RATIO_W-1:0] h);
    quot_t                     res;
    logic [12:0]               prod;
    logic [cbd_pkg::POS_W-1:0] rem;
    prod = 13'(x) * 13'd43;
    rem  = x - {prod[11:7], 1'b0} - prod[12:7];
    unique case (h)
      3'd2:    begin res.q = x >> 1; res.r = {1'b0, x[0]}; end
      3'd3:    begin res.q = prod[12:7]; res.r = rem[1:0]; end
      3'd4:    begin res.q = x >> 2; res.r = x[1:0]; end
      default: begin res.q = x; res.r = 2'd0; end
    endcase
    return res;
  endfunction

  function automatic logic [cbd_pkg::RATIO_W-1:0] clamp_ratio(
      input logic [cbd_pkg::RATIO_W-1:0] r);
    if (r == 3'd0) return 3'd1;
    if (r > 3'd4)  return 3'd4;
    return r;
  endfunction

  function automatic logic [1:0] twos(input logic [cbd_pkg::RATIO_W-1:0] r);
    if (r == 3'd2) return 2'd1;
    if (r == 3'd4) return 2'd2;
    return 2'd0;
  endfunction

  logic [cbd_pkg::POS_W-1:0]   col, row;
  logic [cbd_pkg::HSUM_W-1:0]  row_sum;
  logic [cbd_pkg::POS_W-1:0]   w, ht;
  logic [cbd_pkg::RATIO_W-1:0] h, v;
  quot_t                       cs, rs;
  logic [cbd_pkg::HSUM_W-1:0]  hsum;
  logic                        complete, end_col, end_row, accept;
  logic [1:0]                  threes;
  logic [2:0]                  h_m1, v_m1;

  always_comb begin
    if (cfg.width == '0)                      w = 6'd1;
    else if (int'(cfg.width) > cbd_pkg::MAX_WIDTH) w = cbd_pkg::POS_W'(cbd_pkg::MAX_WIDTH);
    else                                      w = cfg.width;
    if (cfg.height == '0)                     ht = 6'd1;
    else if (int'(cfg.height) > cbd_pkg::MAX_HEIGHT) ht = cbd_pkg::POS_W'(cbd_pkg::MAX_HEIGHT);
    else                                      ht = cfg.height;
  end

  assign h        = clamp_ratio(cfg.horiz);
  assign v        = clamp_ratio(cfg.vert);
  assign h_m1     = h - 3'd1;
  assign v_m1     = v - 3'd1;
  assign cs       = ratio_split(col, h);
  assign rs       = ratio_split(row, v);
  assign complete = (cs.r == h_m1[1:0]);
  assign end_col  = ({1'b0, col} + 7'd1) >= {1'b0, w};
  assign end_row  = ({1'b0, row} + 7'd1) >= {1'b0, ht};
  assign hsum     = (cs.r == 2'd0) ? {2'b00, sample_ch.sample}
                                   : row_sum + {2'b00, sample_ch.sample};
  assign threes   = {1'b0, h == 3'd3} + {1'b0, v == 3'd3};

  assign sample_ch.ready = !qstat.full;
  assign accept          = sample_ch.valid && sample_ch.ready;
  assign push            = accept && complete;

  always_comb begin
    entry.hsum      = hsum;
    entry.column    = cs.q[cbd_pkg::COL_IDX_W-1:0];
    entry.column_ok = int'(cs.q) < cbd_pkg::MAX_WIDTH;
    entry.fresh     = (rs.r == 2'd0);
    entry.emit      = (rs.r == v_m1[1:0]);
    entry.last      = end_col && end_row;
    entry.div_shift = {1'b0, twos(h)} + {1'b0, twos(v)};
    unique case (threes)
      2'd0:    entry.div_mode = cbd_pkg::DIV_ONE;
      2'd1:    entry.div_mode = cbd_pkg::DIV_THREE;
      default: entry.div_mode = cbd_pkg::DIV_NINE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col     <= '0;
      row     <= '0;
      row_sum <= '0;
    end else if (accept) begin
      if (end_col) begin
        col     <= '0;
        row_sum <= '0;
        row     <= end_row ? '0 : row + 6'd1;
      end else begin
        col     <= col + 6'd1;
        row_sum <= complete ? '0 : hsum;
      end
    end
  end

endmodule

/* sv/cbd_queue.sv */
// Short FIFO of completed horizontal groups between front and back.
// Depends on cbd_pkg.
module cbd_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  cbd_pkg::group_t        entry,
  input  logic                   pop,
  output cbd_pkg::group_t        head,
  output cbd_pkg::queue_status_t qstat
);

  cbd_pkg::group_t            slots [cbd_pkg::QUEUE_DEPTH];
  logic [cbd_pkg::QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [cbd_pkg::QCNT_W-1:0] count;

  assign head            = slots[rd_ptr];
  assign qstat.count     = count;
  assign qstat.not_empty = (count != '0);
  assign qstat.full      = (count == cbd_pkg::QCNT_W'(cbd_pkg::QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* sv/cbd_back.sv */
// Back end: column accumulators, group-size division and the output register.
// Depends on cbd_pkg, cbd_if.
module cbd_back (
  input  logic                   clk,
  input  logic                   rst,
  input  cbd_pkg::group_t        head,
  input  cbd_pkg::queue_status_t qstat,
  output logic                   pop,
  average_if.source              average_ch
);

  logic [cbd_pkg::ACC_W-1:0] column_acc [cbd_pkg::MAX_WIDTH];

  cbd_pkg::group_t               grp;
  logic                          grp_valid;
  logic [cbd_pkg::ACC_W-1:0]     grp_prev;
  logic [cbd_pkg::ACC_W-1:0]     prev, acc;
  logic                          grp_fire, grp_free, acc_write;
  logic                          out_free, s1_free;
  logic                          s1_valid, s1_last;
  logic [cbd_pkg::ACC_W-1:0]     s1_value;
  logic [1:0]                    s1_mode;
  logic [cbd_pkg::ACC_W-1:0]     recip;
  logic [2*cbd_pkg::ACC_W-1:0]   prod, quot;
  logic                          out_valid;

  assign prev = (grp.fresh || !grp.column_ok) ? '0 : grp_prev;
  assign acc  = prev + {2'b00, grp.hsum};

  assign out_free  = !out_valid || average_ch.ready;
  assign s1_free   = !s1_valid || out_free;
  assign grp_fire  = grp_valid && (!grp.emit || s1_free);
  assign grp_free  = !grp_valid || grp_fire;
  assign pop       = qstat.not_empty && grp_free;
  assign acc_write = grp_fire && !grp.emit && grp.column_ok;

  // Read the popped group's column into grp_prev as it is popped; forward a same-column write
  always_ff @(posedge clk) begin
    if (acc_write) column_acc[grp.column] <= acc;
    if (pop) begin
      grp      <= head;
      grp_prev <= (acc_write && grp.column == head.column) ? acc : column_acc[head.column];
    end
  end

  always_comb begin
    unique case (s1_mode)
      cbd_pkg::DIV_THREE: recip = cbd_pkg::RECIP3;
      cbd_pkg::DIV_NINE:  recip = cbd_pkg::RECIP9;
      default:            recip = 12'd1;
    endcase
    prod = (2*cbd_pkg::ACC_W)'(s1_value) * (2*cbd_pkg::ACC_W)'(recip);
    unique case (s1_mode)
      cbd_pkg::DIV_THREE: quot = prod >> cbd_pkg::RECIP3_SHIFT;
      cbd_pkg::DIV_NINE:  quot = prod >> cbd_pkg::RECIP9_SHIFT;
      default:            quot = prod;
    endcase
  end

  always_ff @(posedge clk) begin
    if (s1_free) begin
      s1_value <= acc >> grp.div_shift;
      s1_mode  <= grp.div_mode;
      s1_last  <= grp.last;
    end
    if (out_free) begin
      average_ch.average        <= quot[cbd_pkg::SAMPLE_W-1:0];
      average_ch.last_of_region <= s1_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grp_valid <= 1'b0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (grp_free) grp_valid <= pop;
      if (s1_free)  s1_valid  <= grp_fire && grp.emit;
      if (out_free) out_valid <= s1_valid;
    end
  end

  assign average_ch.valid = out_valid;

endmodule

/* sv/chroma_box_downsampler.sv */
// Chroma box downsampler: averages each horiz-by-vert group of 8-bit samples.
// Throughput: one sample per cycle; the front takes a sample whenever the
// four-entry group queue has room, the back retires one queued group a cycle unless the output stalls.
// Path: once its completing sample is taken, an average passes the queue, the
// accumulator read, the divide stage and the output register.
// Reset: synchronous rst clears positions, sums, queue and valids, not accumulators.
module chroma_box_downsampler (
  input  logic                            clk,
  input  logic                            rst,
  sample_if.sink                          sample_ch,
  average_if.source                       average_ch,
  input  logic                            cfg_write_en,
  input  logic [cbd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cbd_pkg::CFG_W-1:0]       cfg_data
);
  // Accumulators are not cleared: each is written at the top row of a band before it is read.

  cbd_pkg::cfg_t          cfg;
  cbd_pkg::group_t        entry, head;
  cbd_pkg::queue_status_t qstat;
  logic                   push, pop;

  // Configuration registers, taken at once; the user must make writes only while idle, which the block does not enforce
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width  <= cbd_pkg::RESET_WIDTH;
      cfg.height <= cbd_pkg::RESET_HEIGHT;
      cfg.horiz  <= cbd_pkg::RESET_HORIZ;
      cfg.vert   <= cbd_pkg::RESET_VERT;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        cbd_pkg::CFG_REGION_WIDTH:  cfg.width  <= cfg_data;
        cbd_pkg::CFG_REGION_HEIGHT: cfg.height <= cfg_data;
        cbd_pkg::CFG_HORIZ_RATIO:   cfg.horiz  <= cfg_data[cbd_pkg::RATIO_W-1:0];
        cbd_pkg::CFG_VERT_RATIO:    cfg.vert   <= cfg_data[cbd_pkg::RATIO_W-1:0];
      endcase
    end
  end

  // Front: position tracking, running horizontal sum, group classification
  cbd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .sample_ch (sample_ch),
    .qstat     (qstat),
    .push      (push),
    .entry     (entry)
  );

  // Group queue: decouples sample intake from output back-pressure
  cbd_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .entry (entry),
    .pop   (pop),
    .head  (head),
    .qstat (qstat)
  );

  // Back: accumulate down the band, divide and hold the result for the sink
  cbd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .qstat      (qstat),
    .pop        (pop),
    .average_ch (average_ch)
  );

  // Queue occupancy never exceeds its depth
  assert property (@(posedge clk) disable iff (rst)
    qstat.count <= cbd_pkg::QCNT_W'(cbd_pkg::QUEUE_DEPTH))
    else $error("group queue overflow");

  // Back only retires a group that is actually queued
  assert property (@(posedge clk) disable iff (rst) pop |-> qstat.not_empty)
    else $error("pop from empty group queue");

  // A request on the output side never survives reset
  assert property (@(posedge clk) $past(rst) |-> !average_ch.valid)
    else $error("output valid right after reset");

endmodule

/* sim/testbench.sv */
// Self-checking testbench for chroma_box_downsampler: directed table, then random regions.
// Depends on cbd_pkg, the sample_if/average_if interfaces and the downsampler RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cbd_pkg::*;

  localparam int RANDOM_ITEMS  = 630;   // random requests after the directed table
  localparam int SETTLE_CYCLES = 10;    // idle wait that lets queued groups with no output drain
  localparam int QUIET_LIMIT   = 1000;  // cycles with no request moving on either channel
  localparam int RAW_MAX       = 63;    // largest value a 6-bit size register can hold
  localparam int MAX_REPORTS   = 20;
  localparam int SCRIPT_ROWS   = 41;

  typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_e;

  // One row of the directed table: a register write or a sample. Where typed is set,
  // mean/flag is the average written out by hand; otherwise the predictor supplies it.
  typedef struct {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_W-1:0]      data;
    logic [SAMPLE_W-1:0]   sample;
    bit                    typed;
    logic [SAMPLE_W-1:0]   mean;
    bit                    flag;
  } step_t;

  typedef struct {
    logic [SAMPLE_W-1:0] mean;
    logic                flag;
  } group_mean_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                 cfg_write_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  sample_if  sample_ch();
  average_if average_ch();

  chroma_box_downsampler DUT (
    .clk          (clk),
    .rst          (rst),
    .sample_ch    (sample_ch),
    .average_ch   (average_ch),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor state: register copies, raster position, running horizontal sum
  // and one partial band sum per output column.
  // ---------------------------------------------------------------------------
  logic [POS_W-1:0]   set_width  = RESET_WIDTH;
  logic [POS_W-1:0]   set_height = RESET_HEIGHT;
  logic [RATIO_W-1:0] set_horiz  = RESET_HORIZ;
  logic [RATIO_W-1:0] set_vert   = RESET_VERT;
  logic [POS_W-1:0]   cur_col    = '0;
  logic [POS_W-1:0]   cur_row    = '0;
  logic [HSUM_W-1:0]  run_sum    = '0;
  logic [ACC_W-1:0]   band_sum [MAX_WIDTH];

  group_mean_t pending_averages [$];
  group_mean_t oldest;

  int  mismatches    = 0;
  int  samples_sent  = 0;
  int  random_sent   = 0;
  int  averages_seen = 0;
  int  settings_used = 0;
  int  quiet_cycles  = 0;
  bit  calm          = 1'b0;   // when set, both sides run without idling

  // Directed table. Starts from the reset setting (16x16, 2x2) with positions at zero.
  step_t script [SCRIPT_ROWS] = '{
    // 1x1 groups on a 1x1 region: every sample comes straight back, flagged last
    '{ROW_WRITE,  CFG_REGION_WIDTH,  6'd1, 8'h00, 1'b0, 8'h00, 1'b0},
    '{ROW_WRITE,  CFG_REGION_HEIGHT, 6'd1, 8'h00, 1'b0, 8'h00, 1'b0},
    '{ROW_WRITE,  CFG_HORIZ_RATIO,   6'd1, 8'h00, 1'b0, 8'h00, 1'b0},
    '{ROW_WRITE,  CFG_VERT_RATIO,    6'd1, 8'h00, 1'b0, 8'h00, 1'b0},
    '{ROW_SAMPLE, CFG_REGION_WIDTH,  6'd0, 8'h00, 1'b1, 8'h00, 1'b1},
    '{ROW_SAMPLE, CFG_REGION_WIDTH,  6'd0, 8'hFF, 1'b1, 8'hFF, 1'b1},
    '{ROW_SAMPLE, CFG_REGION_WIDTH,  6'd0, 8'hA5, 1'b1, 8'hA5, 1'b1},
    '{ROW_SAMPLE, CFG_REGION_WIDTH,  6'd0, 8'h5A, 1'b1, 8'h5A, 1'b1},
    // one 2x2 group of full-scale samples: largest sums, mean stays 255
    '{ROW_WRITE,  CFG_REGION_WIDTH,  6'd2, 8'h00, 1'b0, 8'h00, 1'b0},
    '{ROW_WRITE,  CFG_REGION_HEIGHT, 6'd2, 8'h00, 1'b0, 8'h00, 1'b0},
    '{ROW_WRITE,  CFG_HORIZ_RATIO,   6'd2, 8'h00, 1'b0, 8'h00, 1'b0},
    '{ROW_WRITE,  CFG_VERT_RATIO,    6'd2, 8'h00, 1'b0, 8'h00, 1'b0},
    '{ROW_SAMPLE, CFG_REGION_WIDTH,  6'd0, 8'hFF, 1'b0, 8'h00, 1'b0},
    '{ROW_SAMPLE, CFG_REGION_WIDTH,  6'd0, 8'hFF, 1'b0, 8'h00, 1'b0},
    '{ROW_SAMPLE, CFG_REGION_WIDTH,  6'd0, 8'hFF, 1'b0, 8'h00, 1'b0},
    '{ROW_SAMPLE, CFG_REGION_WIDTH,  6'd0, 8'hFF, 1'b1, 8'hFF, 1'b1},
    // out-of-range values: width 0 acts as 1, ratio 0 as 1, ratio 7 as 4
    '{ROW_WRITE,  CFG_REGION_WIDTH,  6'd0, 8'h00, 1'b0, 8'h00, 1'b0},
    '{ROW_WRITE,  CFG_REGION_HEIGHT, 6'd4, 8'h00, 1'b0, 8'h00, 1'b0},
    '{ROW_WRITE,  CFG_HORIZ_RATIO,   6'd0, 8'h00, 1'b0, 8'h00, 1'b0},
    '{ROW_WRITE,  CFG_VERT_RATIO,    6'd7, 8'h00, 1'b0, 8'h00, 1'b0},
    '{ROW_SAMPLE, CFG_REGION_WIDTH,  6'd0, 8'd1,  1'b0, 8'h00, 1'b0},
    '{ROW_SAMPLE, CFG_REGION_WIDTH,  6'd0, 8'd2,  1'b0, 8'h00, 1'b0},
    '{ROW_SAMPLE, CFG_REGION_WIDTH,  6'd0, 8'd3,  1'b0, 8'h00, 1'b0},
    '{ROW_SAMPLE, CFG_REGION_WIDTH,  6'd0, 8'd6,  1'b1, 8'd3,  1'b1},
    // width not a multiple of the ratio: trailing sample is dropped, no last flag
    '{ROW_WRITE,  CFG_REGION_WIDTH,  6'd3, 8'h00, 1'b0, 8'h00, 1'b0},
    '{ROW_WRITE,  CFG_REGION_HEIGHT, 6'd1, 8'h00, 1'b0, 8'h00, 1'b0},
    '{ROW_WRITE,  CFG_HORIZ_RATIO,   6'd2, 8'h00, 1'b0, 8'h00, 1'b0},
    '{ROW_WRITE,  CFG_VERT_RATIO,    6'd1, 8'h00, 1'b0, 8'h00, 1'b0},
    '{ROW_SAMPLE, CFG_REGION_WIDTH,  6'd0, 8'd10, 1'b0, 8'h00, 1'b0},
    '{ROW_SAMPLE, CFG_REGION_WIDTH,  6'd0, 8'd21, 1'b1, 8'd15, 1'b0},
    '{ROW_SAMPLE, CFG_REGION_WIDTH,  6'd0, 8'd99, 1'b0, 8'h00, 1'b0},
    // shrink the width mid-row: the next sample wraps the column and advances the row
    '{ROW_WRITE,  CFG_REGION_WIDTH,  6'd4, 8'h00, 1'b0, 8'h00, 1'b0},
    '{ROW_WRITE,  CFG_REGION_HEIGHT, 6'd2, 8'h00, 1'b0, 8'h00, 1'b0},
    '{ROW_WRITE,  CFG_HORIZ_RATIO,   6'd1, 8'h00, 1'b0, 8'h00, 1'b0},
    '{ROW_SAMPLE, CFG_REGION_WIDTH,  6'd0, 8'd7,  1'b0, 8'h00, 1'b0},
    '{ROW_SAMPLE, CFG_REGION_WIDTH,  6'd0, 8'd8,  1'b0, 8'h00, 1'b0},
    '{ROW_SAMPLE, CFG_REGION_WIDTH,  6'd0, 8'd9,  1'b0, 8'h00, 1'b0},
    '{ROW_WRITE,  CFG_REGION_WIDTH,  6'd2, 8'h00, 1'b0, 8'h00, 1'b0},
    '{ROW_SAMPLE, CFG_REGION_WIDTH,  6'd0, 8'd40, 1'b0, 8'h00, 1'b0},
    '{ROW_SAMPLE, CFG_REGION_WIDTH,  6'd0, 8'd41, 1'b0, 8'h00, 1'b0},
    '{ROW_SAMPLE, CFG_REGION_WIDTH,  6'd0, 8'd42, 1'b0, 8'h00, 1'b0}
  };

  function automatic int clamp_range(input int val, input int lo, input int hi);
    return (val < lo) ? lo : ((val > hi) ? hi : val);
  endfunction

  // Advance the predictor by one sample; returns 1 when a group completes.
  function automatic bit box_average(input logic [SAMPLE_W-1:0] s,
                                     output logic [SAMPLE_W-1:0] mean, output logic flag);
    int w, ht, h, v, col, row, hsum, g, prev, acc;
    bit end_col, end_row, made;
    w  = clamp_range(set_width, 1, MAX_WIDTH);
    ht = clamp_range(set_height, 1, MAX_HEIGHT);
    h  = clamp_range(set_horiz, 1, 4);
    v  = clamp_range(set_vert, 1, 4);
    col = cur_col;
    row = cur_row;
    end_col = (col + 1 >= w);
    end_row = (row + 1 >= ht);
    made = 1'b0;
    mean = '0;
    flag = 1'b0;

    // restart the horizontal sum at the first column of each group
    hsum = (col % h == 0) ? int'(s) : ((int'(run_sum) + int'(s)) & 'h3FF);

    if (col % h == h - 1) begin
      g    = col / h;
      prev = (row % v != 0 && g < MAX_WIDTH) ? int'(band_sum[g]) : 0;
      acc  = (prev + hsum) & 'hFFF;
      if (row % v == v - 1) begin
        mean = SAMPLE_W'(acc / (h * v));
        flag = end_col && end_row;
        made = 1'b1;
      end else if (g < MAX_WIDTH) begin
        band_sum[g] = ACC_W'(acc);
      end
      run_sum = '0;
    end else begin
      run_sum = HSUM_W'(hsum);
    end

    // wrap at the row end, drop any partial group
    if (end_col) begin
      cur_col = '0;
      run_sum = '0;
      cur_row = end_row ? '0 : POS_W'(row + 1);
    end else begin
      cur_col = POS_W'(col + 1);
    end
    return made;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // Offer one sample request, hold it until accepted, then log what it should produce.
  task automatic send_sample(input logic [SAMPLE_W-1:0] s, input bit typed,
                             input logic [SAMPLE_W-1:0] t_mean, input bit t_flag);
    int gap;
    logic [SAMPLE_W-1:0] p_mean;
    logic p_flag;
    bit made;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_ch.valid  <= 1'b1;
    sample_ch.sample <= s;
    do @(posedge clk); while (!sample_ch.ready);
    made = box_average(s, p_mean, p_flag);
    if (typed) pending_averages.push_back(group_mean_t'{t_mean, t_flag});
    else if (made) pending_averages.push_back(group_mean_t'{p_mean, p_flag});
    samples_sent++;
  endtask

  // Drop valid, wait for every pending average, then let groups with no output drain.
  task automatic settle();
    sample_ch.valid <= 1'b0;
    while (pending_averages.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Drive the write until a clock edge takes it and mirror it into the predictor. The caller lowers
  // the enable after the last write of a burst.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= data;
    @(posedge clk);
    case (idx)
      CFG_REGION_WIDTH:  set_width  = data;
      CFG_REGION_HEIGHT: set_height = data;
      CFG_HORIZ_RATIO:   set_horiz  = data[RATIO_W-1:0];
      CFG_VERT_RATIO:    set_vert   = data[RATIO_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] ht,
                               input logic [CFG_W-1:0] h, input logic [CFG_W-1:0] v,
                               input logic [3:0] mask);
    if (mask[0]) write_reg(CFG_REGION_WIDTH, w);
    if (mask[1]) write_reg(CFG_REGION_HEIGHT, ht);
    if (mask[2]) write_reg(CFG_HORIZ_RATIO, h);
    if (mask[3]) write_reg(CFG_VERT_RATIO, v);
    cfg_write_en <= 1'b0;
    settings_used++;
  endtask

  // ---------------------------------------------------------------------------
  // Average receiver: stall a random number of cycles before taking each request.
  // ---------------------------------------------------------------------------
  initial begin
    int stall;
    average_ch.ready <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        average_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      average_ch.ready <= 1'b1;
      do @(posedge clk); while (!(average_ch.valid && average_ch.ready));
    end
  end

  // Compare every accepted average with the oldest pending one.
  always @(posedge clk) begin
    if (!rst && average_ch.valid && average_ch.ready) begin
      averages_seen++;
      if (pending_averages.size() == 0) begin
        report_mismatch($sformatf("average %0d (last %0b) arrived with nothing pending",
                                  average_ch.average, average_ch.last_of_region));
      end else begin
        oldest = pending_averages.pop_front();
        if (average_ch.average !== oldest.mean)
          report_mismatch($sformatf("average got %0d expected %0d",
                                    average_ch.average, oldest.mean));
        if (average_ch.last_of_region !== oldest.flag)
          report_mismatch($sformatf("last_of_region got %0b expected %0b",
                                    average_ch.last_of_region, oldest.flag));
      end
    end
  end

  // Watchdog: end the run if no request moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (sample_ch.valid && sample_ch.ready) || (average_ch.valid && average_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no request moved for %0d cycles, %0d averages still pending",
               quiet_cycles, pending_averages.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int w, ht, h, v, pick, groups, region, count, mask;
    for (int i = 0; i < MAX_WIDTH; i++) band_sum[i] = '0;
    sample_ch.valid  <= 1'b0;
    sample_ch.sample <= '0;
    cfg_write_en     <= 1'b0;
    cfg_index        <= CFG_REGION_WIDTH;
    cfg_data         <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table. Each burst of writes waits for the block to go idle.
    for (int i = 0; i < SCRIPT_ROWS; i++) begin
      if (script[i].kind == ROW_WRITE) begin
        if (i == 0 || script[i-1].kind != ROW_WRITE) settle();
        write_reg(script[i].index, script[i].data);
        if (i + 1 == SCRIPT_ROWS || script[i+1].kind != ROW_WRITE) begin
          cfg_write_en <= 1'b0;
          settings_used++;
        end
      end else begin
        send_sample(script[i].sample, script[i].typed, script[i].mean, script[i].flag);
      end
    end

    // Fill every column accumulator once (full-width row with a band of two rows),
    // so that later mid-region setting changes never read a column that holds nothing.
    settle();
    apply_setting(CFG_W'(MAX_WIDTH), 6'd2, 6'd1, 6'd2, 4'hF);
    repeat (2 * MAX_WIDTH) begin
      send_sample(SAMPLE_W'($urandom_range(0, 255)), 1'b0, '0, 1'b0);
      random_sent++;
    end

    // Random settings, each followed by whole regions of random samples; now and then
    // stop part way so the next setting lands mid-region.
    while (random_sent < RANDOM_ITEMS) begin
      settle();
      calm = ($urandom_range(0, 3) == 0);
      h = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
      v = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
      pick = $urandom_range(0, 19);
      if (pick < 14) begin
        // sizes that are multiples of the ratios, mostly small
        groups = MAX_WIDTH / clamp_range(h, 1, 4);
        w  = clamp_range(h, 1, 4) *
             ((pick == 0) ? groups : $urandom_range(1, (groups < 4) ? groups : 4));
        ht = clamp_range(v, 1, 4) * $urandom_range(1, 3);
      end else if (pick < 17) begin
        w  = $urandom_range(1, MAX_WIDTH);
        ht = $urandom_range(1, 6);
      end else begin
        case ($urandom_range(0, 3))
          0: w = 0;
          1: w = 1;
          2: w = MAX_WIDTH;
          default: w = RAW_MAX;
        endcase
        case ($urandom_range(0, 3))
          0: ht = 0;
          1: ht = 1;
          2: ht = MAX_HEIGHT;
          default: ht = RAW_MAX;
        endcase
      end
      region = clamp_range(w, 1, MAX_WIDTH) * clamp_range(ht, 1, MAX_HEIGHT);
      if ($urandom_range(0, 6) == 0) count = $urandom_range(1, 30);
      else if (region <= 160) count = region * $urandom_range(1, 2);
      else count = $urandom_range(30, 100);
      if (count > RANDOM_ITEMS - random_sent) count = RANDOM_ITEMS - random_sent;
      mask = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 15;

      apply_setting(CFG_W'(w), CFG_W'(ht), CFG_W'(h), CFG_W'(v), 4'(mask));
      repeat (count) begin
        send_sample(SAMPLE_W'($urandom_range(0, 255)), 1'b0, '0, 1'b0);
        random_sent++;
      end
    end

    // Drain everything still in flight before the verdict.
    settle();

    $display("Sent %0d samples (%0d from the table, %0d random) under %0d register settings,",
             samples_sent, samples_sent - random_sent, random_sent, settings_used);
    $display("checked %0d averages, %0d mismatches.", averages_seen, mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
